// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/mhce_pkg.sv =====
// Types, codes and constants of the mono host-data color expander.
// No dependencies.
`default_nettype none
package mhce_pkg;

   localparam int unsigned FRAME_BYTES_DEF = 8388608;
   localparam int unsigned CMD_DEPTH_DEF   = 2;
   localparam int unsigned RSP_DEPTH_DEF   = 2;
   localparam int unsigned ADDR_W          = 32;

   // item function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   // register indexes
   localparam logic [2:0] REG_DEST_POSITION     = 3'd0;
   localparam logic [2:0] REG_BLOCK_SIZE        = 3'd1;
   localparam logic [2:0] REG_PIXEL_COLORS      = 3'd2;
   localparam logic [2:0] REG_MODE_FLAGS        = 3'd3;
   localparam logic [2:0] REG_CLIP_TOP_LEFT     = 3'd4;
   localparam logic [2:0] REG_CLIP_BOTTOM_RIGHT = 3'd5;
   localparam logic [2:0] REG_SURFACE_BASE      = 3'd6;
   localparam logic [2:0] REG_SURFACE_GEOMETRY  = 3'd7;

   typedef struct packed {
      logic [28:0] dest_position;
      logic [28:0] block_size;
      logic [31:0] pixel_colors;
      logic [7:0]  mode_flags;
      logic [28:0] clip_top_left;
      logic [28:0] clip_bottom_right;
      logic [22:0] surface_base;
      logic [28:0] surface_geometry;
   } cfg_type;

   // one entry of the front-to-back queue
   typedef struct packed {
      logic              func;
      logic [31:0]       data_word;
      cfg_type           cfg;
      logic [22:0]       surface_rows;
      logic [ADDR_W-1:0] row_base;
   } cmd_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [22:0] write_address;
      logic [15:0] pixel_value;
      logic        command_active;
      logic        data_error;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_BITS,
      B_STAT
   } back_state_type;

endpackage
`default_nettype wire

// ===== src/mhce_fifo.sv =====
// Small register queue used between front and back and at the result side.
// Depends on nothing but its parameters.
`default_nettype none
module mhce_fifo #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      rdata
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = cnt_ff == CNT_W'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rptr_ff];

   // pointer and count update
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

// ===== src/mhce_front.sv =====
// Front part: register file, item intake, surface row division and row base.
// Depends on mhce_pkg.
`default_nettype none
module mhce_front #(
   parameter int unsigned FRAME_BYTES = mhce_pkg::FRAME_BYTES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output logic              req_full,
   input  wire logic         req_func,
   input  wire logic [31:0]  req_data_word,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data,
   input  wire logic         cmd_full,
   output logic              cmd_push,
   output mhce_pkg::cmd_type cmd_entry
);
   localparam int unsigned DIV_W = $clog2(FRAME_BYTES + 1);
   localparam int unsigned CNT_W = $clog2(DIV_W + 1);

   mhce_pkg::cfg_type         cfg_ff, snap_ff, snap_in;
   mhce_pkg::front_state_type state_ff, state_in;
   logic [DIV_W-1:0]          dvd_ff, dvd_in, quot_ff, quot_in;
   logic [16:0]               rem_ff, rem_in, trial;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [28:0]               prod_ff, prod_in;
   logic                      accept;
   logic [15:0]               pitch;
   logic [31:0]               quot_ext;
   logic [22:0]               rows_sat;

   assign csr_ready = 1'b1;
   assign req_full  = (state_ff != mhce_pkg::F_IDLE) || cmd_full;
   assign accept    = req_push && !req_full;
   assign pitch     = snap_ff.surface_geometry[15:0];
   assign trial     = {rem_ff[15:0], dvd_ff[DIV_W-1]};
   assign quot_ext  = 32'(quot_ff);
   assign rows_sat  = (quot_ext > 32'h7F_FFFF) ? 23'h7F_FFFF : quot_ext[22:0];

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mhce_pkg::REG_DEST_POSITION:     cfg_ff.dest_position     <= csr_data[28:0];
            mhce_pkg::REG_BLOCK_SIZE:        cfg_ff.block_size        <= csr_data[28:0];
            mhce_pkg::REG_PIXEL_COLORS:      cfg_ff.pixel_colors      <= csr_data;
            mhce_pkg::REG_MODE_FLAGS:        cfg_ff.mode_flags        <= csr_data[7:0];
            mhce_pkg::REG_CLIP_TOP_LEFT:     cfg_ff.clip_top_left     <= csr_data[28:0];
            mhce_pkg::REG_CLIP_BOTTOM_RIGHT: cfg_ff.clip_bottom_right <= csr_data[28:0];
            mhce_pkg::REG_SURFACE_BASE:      cfg_ff.surface_base      <= csr_data[22:0];
            mhce_pkg::REG_SURFACE_GEOMETRY:  cfg_ff.surface_geometry  <= csr_data[28:0];
            default: ;
         endcase
      end
   end

   // intake: data beats pass on, a start divides (base < frame, pitch != 0)
   always_comb begin
      state_in  = state_ff;
      snap_in   = snap_ff;
      dvd_in    = dvd_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      cmd_push  = 1'b0;
      cmd_entry = '0;
      case (state_ff)
         mhce_pkg::F_IDLE: begin
            if (accept) begin
               if (req_func == mhce_pkg::FUNC_DATA) begin
                  cmd_push            = 1'b1;
                  cmd_entry.func      = mhce_pkg::FUNC_DATA;
                  cmd_entry.data_word = req_data_word;
               end else begin
                  snap_in = cfg_ff;
                  rem_in  = '0;
                  cnt_in  = '0;
                  quot_in = '0;
                  dvd_in  = DIV_W'(FRAME_BYTES) - DIV_W'(cfg_ff.surface_base);
                  if ((32'(cfg_ff.surface_base) < 32'(FRAME_BYTES)) &&
                      (cfg_ff.surface_geometry[15:0] != '0)) begin
                     state_in = mhce_pkg::F_DIV;
                  end else begin
                     state_in = mhce_pkg::F_MUL;
                  end
               end
            end
         end
         mhce_pkg::F_DIV: begin
            // one quotient bit per cycle
            dvd_in = dvd_ff << 1;
            if (trial >= {1'b0, pitch}) begin
               rem_in  = trial - {1'b0, pitch};
               quot_in = {quot_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in  = trial;
               quot_in = {quot_ff[DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               state_in = mhce_pkg::F_MUL;
            end
         end
         mhce_pkg::F_MUL: begin
            prod_in  = snap_ff.dest_position[28:16] * pitch;
            state_in = mhce_pkg::F_PUSH;
         end
         mhce_pkg::F_PUSH: begin
            if (!cmd_full) begin
               cmd_push               = 1'b1;
               cmd_entry.func         = mhce_pkg::FUNC_START;
               cmd_entry.cfg          = snap_ff;
               cmd_entry.surface_rows = rows_sat;
               cmd_entry.row_base     = mhce_pkg::ADDR_W'(snap_ff.surface_base) +
                                        mhce_pkg::ADDR_W'(prod_ff);
               state_in               = mhce_pkg::F_IDLE;
            end
         end
         default: state_in = mhce_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhce_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

// ===== src/mhce_back.sv =====
// Back part: command state, bit-serial expansion, pixel checks and status.
// Depends on mhce_pkg.
`default_nettype none
module mhce_back #(
   parameter int unsigned FRAME_BYTES = mhce_pkg::FRAME_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_empty,
   output logic                   cmd_pop,
   input  wire mhce_pkg::cmd_type cmd_entry,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output mhce_pkg::rsp_type      rsp_entry
);
   localparam int unsigned AW = mhce_pkg::ADDR_W;

   mhce_pkg::back_state_type state_ff, state_in;
   mhce_pkg::cfg_type        cfg_ff, cfg_in;
   logic [22:0]              srows_ff, srows_in;
   logic [AW-1:0]            rowaddr_ff, rowaddr_in;
   logic                     busy_ff, busy_in;
   logic [12:0]              row_ff, row_in;
   logic [10:0]              bir_ff, bir_in, arb_ff, arb_in, srp_ff, srp_in;
   logic [31:0]              word_ff, word_in;
   logic [4:0]               bit_ff, bit_in;

   // fields of the latched command
   logic [12:0] dx, dy, w, h, cr, ct, cb, sw;
   logic [11:0] cl;
   logic [4:0]  boff;
   logic [15:0] fg, bg, pitch;
   logic        transp, clip_en, clip_ex;

   assign dx      = cfg_ff.dest_position[12:0];
   assign dy      = cfg_ff.dest_position[28:16];
   assign w       = cfg_ff.block_size[12:0];
   assign h       = cfg_ff.block_size[28:16];
   assign fg      = cfg_ff.pixel_colors[31:16];
   assign bg      = cfg_ff.pixel_colors[15:0];
   assign transp  = cfg_ff.mode_flags[0];
   assign clip_en = cfg_ff.mode_flags[1];
   assign clip_ex = cfg_ff.mode_flags[2];
   assign boff    = cfg_ff.mode_flags[7:3];
   assign cl      = cfg_ff.clip_top_left[11:0];
   assign ct      = cfg_ff.clip_top_left[28:16];
   assign cr      = cfg_ff.clip_bottom_right[12:0];
   assign cb      = cfg_ff.clip_bottom_right[28:16];
   assign pitch   = cfg_ff.surface_geometry[15:0];
   assign sw      = cfg_ff.surface_geometry[28:16];

   // start-time row sizes
   logic [12:0] nw, nh;
   logic [4:0]  nboff;
   logic [13:0] arb_sum;
   logic [10:0] arb_new, srp_sum;
   logic        busy_new;

   assign nw       = cmd_entry.cfg.block_size[12:0];
   assign nh       = cmd_entry.cfg.block_size[28:16];
   assign nboff    = cmd_entry.cfg.mode_flags[7:3];
   assign arb_sum  = 14'(nboff) + 14'(nw) + 14'd7;
   assign arb_new  = arb_sum[13:3];
   assign srp_sum  = arb_new + 11'd3;
   assign busy_new = (nw != '0) && (nh != '0);

   // current bit: byte bit_ff[4:3], MSB first within the byte
   logic        set_bit, in_w, pix_en, in_clip, clip_ok, sw_ok, rows_ok, addr_ok, pix_ok;
   logic [13:0] bit_pos, px, ax, ay;
   logic [AW-1:0] off;

   assign set_bit = word_ff[{bit_ff[4:3], ~bit_ff[2:0]}];
   assign bit_pos = {bir_ff, bit_ff[2:0]};
   assign px      = bit_pos - 14'(boff);
   assign in_w    = (bit_pos >= 14'(boff)) && (px < 14'(w));
   assign pix_en  = in_w && (bir_ff < arb_ff) && (row_ff < h) && (set_bit || !transp);
   assign ax      = 14'(dx) + 14'(px[12:0]);
   assign ay      = 14'(dy) + 14'(row_ff);
   assign in_clip = (ax >= 14'(cl)) && (ax < 14'(cr)) && (ay >= 14'(ct)) && (ay < 14'(cb));
   assign clip_ok = !clip_en || (clip_ex ? !in_clip : in_clip);
   assign sw_ok   = (sw == '0) || (ax < 14'(sw));
   assign rows_ok = (srows_ff == '0) || (23'(ay) < srows_ff);
   assign off     = rowaddr_ff + AW'({ax, 1'b0});
   assign addr_ok = off < AW'(FRAME_BYTES - 1);
   assign pix_ok  = pix_en && clip_ok && sw_ok && rows_ok && addr_ok;

   // row bookkeeping at the end of a byte
   logic [10:0] bir_inc;
   logic [12:0] row_inc;
   logic        row_done;

   assign bir_inc  = bir_ff + 11'd1;
   assign row_done = bir_inc >= srp_ff;
   assign row_inc  = row_ff + 13'd1;

   always_comb begin
      state_in   = state_ff;
      cfg_in     = cfg_ff;
      srows_in   = srows_ff;
      rowaddr_in = rowaddr_ff;
      busy_in    = busy_ff;
      row_in     = row_ff;
      bir_in     = bir_ff;
      arb_in     = arb_ff;
      srp_in     = srp_ff;
      word_in    = word_ff;
      bit_in     = bit_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp_entry  = '0;
      case (state_ff)
         mhce_pkg::B_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               if (cmd_entry.func == mhce_pkg::FUNC_START) begin
                  // latch the command and report its state
                  cfg_in                   = cmd_entry.cfg;
                  srows_in                 = cmd_entry.surface_rows;
                  rowaddr_in               = cmd_entry.row_base;
                  busy_in                  = busy_new;
                  row_in                   = '0;
                  bir_in                   = '0;
                  arb_in                   = arb_new;
                  srp_in                   = {srp_sum[10:2], 2'b00};
                  rsp_push                 = 1'b1;
                  rsp_entry.command_active = busy_new;
                  rsp_entry.last           = 1'b1;
               end else if (!busy_ff) begin
                  rsp_push             = 1'b1;
                  rsp_entry.data_error = 1'b1;
                  rsp_entry.last       = 1'b1;
               end else begin
                  word_in  = cmd_entry.data_word;
                  bit_in   = '0;
                  state_in = mhce_pkg::B_BITS;
               end
            end
         end
         mhce_pkg::B_BITS: begin
            if (!rsp_full) begin
               rsp_push                 = pix_ok;
               rsp_entry.pixel_valid    = 1'b1;
               rsp_entry.write_address  = off[22:0];
               rsp_entry.pixel_value    = set_bit ? fg : bg;
               rsp_entry.command_active = 1'b1;
               bit_in                   = bit_ff + 5'd1;
               if (bit_ff == 5'd31) begin
                  state_in = mhce_pkg::B_STAT;
               end
               if (bit_ff[2:0] == 3'd7) begin
                  if (row_done) begin
                     bir_in     = '0;
                     row_in     = row_inc;
                     rowaddr_in = rowaddr_ff + AW'(pitch);
                     if (row_inc >= h) begin
                        busy_in  = 1'b0;
                        state_in = mhce_pkg::B_STAT;
                     end
                  end else begin
                     bir_in = bir_inc;
                  end
               end
            end
         end
         mhce_pkg::B_STAT: begin
            if (!rsp_full) begin
               rsp_push                 = 1'b1;
               rsp_entry.command_active = busy_ff;
               rsp_entry.last           = 1'b1;
               state_in                 = mhce_pkg::B_IDLE;
            end
         end
         default: state_in = mhce_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhce_pkg::B_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff     <= cfg_in;
      srows_ff   <= srows_in;
      rowaddr_ff <= rowaddr_in;
      row_ff     <= row_in;
      bir_ff     <= bir_in;
      arb_ff     <= arb_in;
      srp_ff     <= srp_in;
      word_ff    <= word_in;
      bit_ff     <= bit_in;
   end
endmodule
`default_nettype wire

// ===== src/mono_host_data_color_expander.sv =====
// Top level of the mono host-data color expander: front, queues and back.
// Depends on mhce_pkg, mhce_fifo, mhce_front, mhce_back and assert_macros.svh.
//
//   channel   direction  handshake           beat
//   req_      in         push / full         func, data_word
//   rsp_      out        pop / empty         one pixel write or status
//   csr_      in         valid / ready       register index, write data
//
// A data beat is taken from the queue, expanded one source bit per cycle
// while the result queue has room and closed by a status, early once the
// last row is done. A start beat runs the one-bit-per-cycle row count
// divider if base < frame and pitch != 0; stray data gets an error status.
// Reset clears the registers, the queues and the command state.
// Front and back stall on their own around a two-beat queue; results wait
// in a two-beat output queue, and the back keeps going until it is full.
`default_nettype none
`include "assert_macros.svh"
module mono_host_data_color_expander #(
   parameter int unsigned FRAME_BYTES = mhce_pkg::FRAME_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_func,
   input  wire logic [31:0] req_data_word,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_pixel_valid,
   output logic [22:0]      rsp_write_address,
   output logic [15:0]      rsp_pixel_value,
   output logic             rsp_command_active,
   output logic             rsp_data_error,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int unsigned CMD_W = $bits(mhce_pkg::cmd_type);
   localparam int unsigned RSP_W = $bits(mhce_pkg::rsp_type);

   mhce_pkg::cmd_type cmd_wr, cmd_rd;
   mhce_pkg::rsp_type rsp_wr, rsp_rd;
   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic              rsp_push, rsp_full;

   mhce_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_func      (req_func),
      .req_data_word (req_data_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd_entry     (cmd_wr)
   );

   // command queue
   mhce_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (mhce_pkg::CMD_DEPTH_DEF)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (cmd_rd)
   );

   mhce_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_entry (cmd_rd),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_entry (rsp_wr)
   );

   // result queue
   mhce_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (mhce_pkg::RSP_DEPTH_DEF)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_rd)
   );

   assign rsp_pixel_valid    = rsp_rd.pixel_valid;
   assign rsp_write_address  = rsp_rd.write_address;
   assign rsp_pixel_value    = rsp_rd.pixel_value;
   assign rsp_command_active = rsp_rd.command_active;
   assign rsp_data_error     = rsp_rd.data_error;
   assign rsp_last           = rsp_rd.last;

   // pixel beats belong to a running command and never close an item
   `ASSERT_IMPLY(a_pix_active, clock, reset, !rsp_empty && rsp_pixel_valid, rsp_command_active && !rsp_last && !rsp_data_error)
   // an error status is a closing status with no command behind it
   `ASSERT_IMPLY(a_err_status, clock, reset, !rsp_empty && rsp_data_error, rsp_last && !rsp_pixel_valid && !rsp_command_active)
   // a start beat occupies the front for its row count division
   `ASSERT_NEXT(a_start_busy, clock, reset, req_push && !req_full && (req_func == mhce_pkg::FUNC_START), req_full)
   // the back never pushes into a full result queue
   `ASSERT_IMPLY(a_rsp_room, clock, reset, rsp_push, !rsp_full)
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the mono host-data color expander.
// Depends on mhce_pkg and mono_host_data_color_expander.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   localparam int unsigned FRAME = mhce_pkg::FRAME_BYTES_DEF;
   localparam int LIMIT = 900000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_func = 1'b0;
   logic [31:0] req_data_word = '0;
   logic        rsp_pop = 1'b0;
   logic        csr_valid = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   wire         req_full, rsp_empty, csr_ready;
   wire         rsp_pixel_valid, rsp_command_active, rsp_data_error, rsp_last;
   wire  [22:0] rsp_write_address;
   wire  [15:0] rsp_pixel_value;

   mono_host_data_color_expander uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   typedef struct packed {
      logic        func;
      logic [31:0] word;
   } beat_type;

   // predictor state
   logic [31:0] reg_file [8];
   logic [31:0] latched  [8];
   logic        busy;
   int unsigned cur_row, byte_pos, act_bytes, row_pitch, surf_rows;

   beat_type          pending_beats[$];
   mhce_pkg::rsp_type expected_writes[$];
   int       errors = 0;
   int       cycles = 0;
   int       send_idle = 12, recv_idle = 66;
   bit       hold_send = 1'b0;

   task automatic report(input string what);
      errors++;
      $display("tb: mismatch: %s", what);
   endtask

   function automatic mhce_pkg::rsp_type status_beat(input logic act, input logic err);
      mhce_pkg::rsp_type r;
      r = '0;
      r.command_active = act;
      r.data_error = err;
      r.last = 1'b1;
      return r;
   endfunction

   // check one pixel against clip, surface width, rows and frame size
   task automatic plot(input int unsigned px, input logic [15:0] color);
      longint unsigned ax, ay, off, sw;
      logic in_clip;
      logic [31:0] dpos, ctl, cbr, geom, flags;
      mhce_pkg::rsp_type r;
      dpos  = latched[mhce_pkg::REG_DEST_POSITION];
      ctl   = latched[mhce_pkg::REG_CLIP_TOP_LEFT];
      cbr   = latched[mhce_pkg::REG_CLIP_BOTTOM_RIGHT];
      geom  = latched[mhce_pkg::REG_SURFACE_GEOMETRY];
      flags = latched[mhce_pkg::REG_MODE_FLAGS];
      ax = longint'(dpos[12:0]) + px;
      ay = longint'(dpos[28:16]) + cur_row;
      if (flags[1]) begin
         in_clip = ax >= ctl[11:0] && ax < cbr[12:0]
                && ay >= ctl[28:16] && ay < cbr[28:16];
         if (flags[2] ? in_clip : !in_clip) return;
      end
      sw = geom[28:16];
      if (sw != 0 && ax >= sw) return;
      if (surf_rows != 0 && ay >= surf_rows) return;
      off = latched[mhce_pkg::REG_SURFACE_BASE][22:0] + ay * geom[15:0] + ax * 2;
      if (off + 1 >= FRAME) return;
      r = '0;
      r.pixel_valid = 1'b1;
      r.write_address = off[22:0];
      r.pixel_value = color;
      r.command_active = 1'b1;
      expected_writes.insert(expected_writes.size(), r);
   endtask

   task automatic expand_beat(input beat_type b);
      int unsigned w, h, boff, bp;
      longint unsigned base, pitch, rows;
      logic [7:0] byt;
      logic [31:0] colors;
      if (b.func == mhce_pkg::FUNC_START) begin
         latched = reg_file;
         w = latched[mhce_pkg::REG_BLOCK_SIZE][12:0];
         h = latched[mhce_pkg::REG_BLOCK_SIZE][28:16];
         boff = latched[mhce_pkg::REG_MODE_FLAGS][7:3];
         busy = (w != 0) && (h != 0);
         cur_row = 0;
         byte_pos = 0;
         act_bytes = (boff + w + 7) / 8;
         row_pitch = (act_bytes + 3) & ~3;
         base = latched[mhce_pkg::REG_SURFACE_BASE][22:0];
         pitch = latched[mhce_pkg::REG_SURFACE_GEOMETRY][15:0];
         rows = 0;
         if (base < FRAME && pitch != 0) rows = (FRAME - base) / pitch;
         surf_rows = rows > 64'h7FFFFF ? 32'h7FFFFF : int'(rows);
         expected_writes.insert(expected_writes.size(), status_beat(busy, 1'b0));
         return;
      end
      if (!busy) begin
         expected_writes.insert(expected_writes.size(), status_beat(1'b0, 1'b1));
         return;
      end
      w = latched[mhce_pkg::REG_BLOCK_SIZE][12:0];
      h = latched[mhce_pkg::REG_BLOCK_SIZE][28:16];
      boff = latched[mhce_pkg::REG_MODE_FLAGS][7:3];
      colors = latched[mhce_pkg::REG_PIXEL_COLORS];
      for (int n = 0; n < 4 && busy; n++) begin
         byt = b.word[8*n +: 8];
         if (byte_pos < act_bytes && cur_row < h) begin
            for (int i = 0; i < 8; i++) begin
               bp = byte_pos * 8 + i;
               if (bp >= boff && bp - boff < w) begin
                  if (byt[7-i]) plot(bp - boff, colors[31:16]);
                  else if (!latched[mhce_pkg::REG_MODE_FLAGS][0])
                     plot(bp - boff, colors[15:0]);
               end
            end
         end
         byte_pos = (byte_pos + 1) & 11'h7FF;
         if (byte_pos >= row_pitch) begin
            byte_pos = 0;
            cur_row = (cur_row + 1) & 13'h1FFF;
            if (cur_row >= h) busy = 1'b0;
         end
      end
      expected_writes.insert(expected_writes.size(), status_beat(busy, 1'b0));
   endtask

   // input driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            expand_beat('{req_func, req_data_word});
            void'(pending_beats.pop_front());
         end
         if (hold_send || pending_beats.size() == 0
             || $urandom_range(99) < send_idle) begin
            req_push <= 1'b0;
         end else if (!(req_push && req_full)) begin
            req_push <= 1'b1;
            req_func <= pending_beats[0].func;
            req_data_word <= pending_beats[0].word;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      mhce_pkg::rsp_type got, want;
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_pixel_valid, rsp_write_address, rsp_pixel_value,
                    rsp_command_active, rsp_data_error, rsp_last};
            if (expected_writes.size() == 0) report("result with none expected");
            else begin
               want = expected_writes.pop_front();
               if (got.pixel_valid !== want.pixel_valid) report("pixel_valid");
               if (got.write_address !== want.write_address)
                  report($sformatf("write_address %h want %h",
                                   got.write_address, want.write_address));
               if (got.pixel_value !== want.pixel_value) report("pixel_value");
               if (got.command_active !== want.command_active) report("command_active");
               if (got.data_error !== want.data_error) report("data_error");
               if (got.last !== want.last) report("last");
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // one register write; csr_valid is low again when the task returns
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      logic [31:0] mask;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         mhce_pkg::REG_PIXEL_COLORS: mask = 32'hFFFFFFFF;
         mhce_pkg::REG_MODE_FLAGS:   mask = 32'hFF;
         mhce_pkg::REG_SURFACE_BASE: mask = 32'h7FFFFF;
         default:                    mask = 32'h1FFFFFFF;
      endcase
      reg_file[idx] = val & mask;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_beats.size() != 0 || req_push || expected_writes.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic queue_beat(input logic f, input logic [31:0] d);
      beat_type b;
      b.func = f;
      b.word = d;
      pending_beats.insert(pending_beats.size(), b);
   endtask

   // small random command: start then enough words, sometimes broken
   task automatic random_command();
      int unsigned w, h, boff, words;
      w = $urandom_range(1, 40);
      h = $urandom_range(1, 4);
      boff = $urandom_range(31);
      write_reg(mhce_pkg::REG_BLOCK_SIZE, {3'b0, 13'(h), 3'b0, 13'(w)});
      write_reg(mhce_pkg::REG_MODE_FLAGS, {boff[4:0], 3'($urandom_range(7))});
      write_reg(mhce_pkg::REG_PIXEL_COLORS, $urandom);
      write_reg(mhce_pkg::REG_DEST_POSITION, {3'b0, 13'($urandom_range(8191)),
                                              3'b0, 13'($urandom_range(8191))});
      write_reg(mhce_pkg::REG_CLIP_TOP_LEFT, {3'b0, 13'($urandom_range(60)),
                                              4'b0, 12'($urandom_range(60))});
      write_reg(mhce_pkg::REG_CLIP_BOTTOM_RIGHT, $urandom & 32'h1FFF1FFF);
      if ($urandom_range(3) == 0) write_reg(mhce_pkg::REG_SURFACE_BASE, $urandom);
      if ($urandom_range(3) == 0) write_reg(mhce_pkg::REG_SURFACE_GEOMETRY, $urandom);
      queue_beat(mhce_pkg::FUNC_START, $urandom);
      words = ((((boff + w + 7) / 8 + 3) & ~3) * h + 3) / 4;
      if ($urandom_range(5) == 0) words = $urandom_range(words + 2);
      for (int i = 0; i < words; i++) queue_beat(mhce_pkg::FUNC_DATA, $urandom);
      drain();
   endtask

   initial begin
      for (int i = 0; i < 8; i++) reg_file[i] = '0;
      for (int i = 0; i < 8; i++) latched[i] = '0;
      busy = 1'b0;
      cur_row = 0; byte_pos = 0; act_bytes = 0; row_pitch = 0; surf_rows = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray data, empty rectangle, extremes
      queue_beat(mhce_pkg::FUNC_DATA, 32'hFFFFFFFF);
      queue_beat(mhce_pkg::FUNC_START, 32'h0);
      queue_beat(mhce_pkg::FUNC_DATA, 32'h0);
      drain();
      write_reg(mhce_pkg::REG_BLOCK_SIZE, 32'h1FFF0000);
      queue_beat(mhce_pkg::FUNC_START, 32'h0);
      drain();
      // maximal offset, zero pitch, restart mid command
      write_reg(mhce_pkg::REG_BLOCK_SIZE, 32'h00020021);
      write_reg(mhce_pkg::REG_MODE_FLAGS, 32'hFF);
      write_reg(mhce_pkg::REG_PIXEL_COLORS, 32'hFFFF0000);
      write_reg(mhce_pkg::REG_DEST_POSITION, 32'h1FFF1FFF);
      write_reg(mhce_pkg::REG_SURFACE_GEOMETRY, 32'h0);
      queue_beat(mhce_pkg::FUNC_START, 32'h0);
      queue_beat(mhce_pkg::FUNC_DATA, 32'hA5A5A5A5);
      queue_beat(mhce_pkg::FUNC_START, 32'h0);
      drain();
      write_reg(mhce_pkg::REG_MODE_FLAGS, 32'h0A);
      write_reg(mhce_pkg::REG_DEST_POSITION, 32'h0);
      write_reg(mhce_pkg::REG_CLIP_TOP_LEFT, 32'h0);
      write_reg(mhce_pkg::REG_CLIP_BOTTOM_RIGHT, 32'h1FFF1FFF);
      write_reg(mhce_pkg::REG_SURFACE_GEOMETRY, 32'h1FFF0001);
      write_reg(mhce_pkg::REG_BLOCK_SIZE, 32'h00030008);
      queue_beat(mhce_pkg::FUNC_START, 32'h0);
      for (int i = 0; i < 4; i++) queue_beat(mhce_pkg::FUNC_DATA, 32'h5A00FF01 << i);
      drain();
      // base at the last frame byte and near-end addresses
      write_reg(mhce_pkg::REG_SURFACE_BASE, 32'h7FFFFF);
      write_reg(mhce_pkg::REG_SURFACE_GEOMETRY, 32'h0000FFFF);
      write_reg(mhce_pkg::REG_MODE_FLAGS, 32'h0);
      queue_beat(mhce_pkg::FUNC_START, 32'h0);
      queue_beat(mhce_pkg::FUNC_DATA, 32'h12345678);
      drain();
      write_reg(mhce_pkg::REG_SURFACE_BASE, 32'h7FFFF0);
      write_reg(mhce_pkg::REG_SURFACE_GEOMETRY, 32'h1FFF0000);
      queue_beat(mhce_pkg::FUNC_START, 32'h0);
      queue_beat(mhce_pkg::FUNC_DATA, 32'hFFFFFFFF);
      drain();
      write_reg(mhce_pkg::REG_SURFACE_BASE, 32'h0);
      write_reg(mhce_pkg::REG_SURFACE_GEOMETRY, 32'h00000100);

      // random phases with varying idle rates
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle = 66; recv_idle = 12; end
         if (ph == 2) begin send_idle = 0;  recv_idle = 0;  end
         for (int c = 0; c < 18; c++) begin
            if (c == 9) begin
               // sender waits for every result
               hold_send = 1'b1;
               while (expected_writes.size() != 0) @(posedge clock);
               hold_send = 1'b0;
            end
            random_command();
         end
      end

      drain();
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/mhce_pkg.sv
src/mhce_fifo.sv
src/mhce_front.sv
src/mhce_back.sv
src/mono_host_data_color_expander.sv
tb/tb.sv
